// ----- sv/bmw_pkg.sv -----
// Block map walk: shared constants, codes and controller/datapath link types.
// No dependencies; every other file imports this package.

package bmw_pkg;

  // Geometry of the map
  localparam int ADDR_SLOTS      = 7;
  localparam int WORD_SHIFT      = 7;
  localparam int STORE_BLOCKS    = 64;
  localparam int DIRECT_COUNT    = 4;
  localparam int LEVELS          = 3;

  localparam int WORDS_PER_BLOCK = 1 << WORD_SHIFT;
  localparam int STORE_WORDS     = STORE_BLOCKS * WORDS_PER_BLOCK;
  localparam int BLK_W           = $clog2(STORE_BLOCKS);
  localparam int ADDR_W          = BLK_W + WORD_SHIFT;
  localparam int REL_W           = LEVELS * WORD_SHIFT;
  localparam int LEFT_W          = $clog2(LEVELS + 1);

  // Port field widths
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int SBLK_W  = 6;
  localparam int SWORD_W = 7;
  localparam int VAL_W   = 32;
  localparam int DEPTH_W = 3;

  // Cumulative reach of the indirect trees, relative to the first indirect block
  localparam logic [VAL_W-1:0] SPAN1 = VAL_W'(64'(1) << WORD_SHIFT);
  localparam logic [VAL_W-1:0] SPAN2 = VAL_W'(64'(1) << (2 * WORD_SHIFT));
  localparam logic [VAL_W-1:0] SPAN3 = VAL_W'(64'(1) << (3 * WORD_SHIFT));
  localparam logic [VAL_W-1:0] LIM1  = SPAN1;
  localparam logic [VAL_W-1:0] LIM2  = SPAN1 + SPAN2;
  localparam logic [VAL_W-1:0] LIM3  = SPAN1 + SPAN2 + SPAN3;

  typedef enum logic [MODE_W-1:0] {
    MODE_SLOT   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [DEPTH_W-1:0] DEPTH_DIRECT = 3'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_BEYOND = 3'd4;

  typedef struct packed {
    logic take;     // word accepted: capture and perform writes
    logic decode;   // range decode and root fetch
    logic issue;    // store read for current level
    logic kill;     // pointer outside store: result 0
    logic load;     // take store read data as next pointer
    logic emit;     // load output register
  } bmw_cmd_t;

  typedef struct packed {
    logic in_lookup;
    logic dec_walk;
    logic ptr_in_store;
    logic rd_zero;
    logic last_level;
  } bmw_stat_t;

endpackage

// ----- sv/bmw_if.sv -----
// Block map walk: valid/ready channel interfaces for request and result words.
// Depends on bmw_pkg for field widths.

interface bmw_in_if import bmw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [SLOT_W-1:0]  slot_index;
  logic [SBLK_W-1:0]  store_block;
  logic [SWORD_W-1:0] store_word;
  logic [VAL_W-1:0]   write_value;
  logic [VAL_W-1:0]   logical_block;

  modport source (output valid, mode, slot_index, store_block, store_word, write_value,
                  logical_block, input ready);
  modport sink   (input valid, mode, slot_index, store_block, store_word, write_value,
                  logical_block, output ready);
endinterface

interface bmw_out_if import bmw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   physical_block;
  logic               mapped;
  logic [DEPTH_W-1:0] depth;

  modport source (output valid, physical_block, mapped, depth, input ready);
  modport sink   (input valid, physical_block, mapped, depth, output ready);
endinterface

// ----- sv/bmw_ctrl.sv -----
// Block map walk controller: sequences capture, decode, per-level store reads
// and result hand-off. Depends on bmw_pkg.

module bmw_ctrl import bmw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  bmw_stat_t stat,
  output bmw_cmd_t  cmd,
  output logic      in_ready,
  output logic      out_valid
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_WALK   = 5'b00100,
    S_LOAD   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = stat.in_lookup ? S_DECODE : S_FINISH;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = stat.dec_walk ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        if (stat.ptr_in_store) begin
          cmd.issue = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          cmd.kill  = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = (stat.rd_zero || stat.last_level) ? S_FINISH : S_WALK;
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/bmw_dpath.sv -----
// Block map walk datapath: address table, block store memory, range decode,
// walk pointer and output register. Depends on bmw_pkg.

module bmw_dpath import bmw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  bmw_cmd_t           cmd,
  output bmw_stat_t          stat,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [SLOT_W-1:0]  in_slot_index,
  input  logic [SBLK_W-1:0]  in_store_block,
  input  logic [SWORD_W-1:0] in_store_word,
  input  logic [VAL_W-1:0]   in_write_value,
  input  logic [VAL_W-1:0]   in_logical_block,
  output logic [VAL_W-1:0]   out_physical_block,
  output logic               out_mapped,
  output logic [DEPTH_W-1:0] out_depth
);

  logic [VAL_W-1:0] table_r [ADDR_SLOTS];
  logic [VAL_W-1:0] mem [STORE_WORDS];
  logic [VAL_W-1:0] rd_data_r;

  logic [VAL_W-1:0]   logical_r;
  logic [VAL_W-1:0]   ptr_r;
  logic [REL_W-1:0]   rel_r;
  logic [LEFT_W-1:0]  left_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [VAL_W-1:0]   out_phys_r;
  logic               out_mapped_r;
  logic [DEPTH_W-1:0] out_depth_r;

  // write side
  logic [VAL_W-1:0]  blk_ext, word_ext;
  logic              tbl_we, mem_we;
  logic [ADDR_W-1:0] wr_addr;

  assign blk_ext  = VAL_W'(in_store_block);
  assign word_ext = VAL_W'(in_store_word);
  assign tbl_we   = cmd.take && (mode_t'(in_mode) == MODE_SLOT)
                    && (VAL_W'(in_slot_index) < VAL_W'(ADDR_SLOTS));
  assign mem_we   = cmd.take && (mode_t'(in_mode) == MODE_STORE)
                    && (blk_ext < VAL_W'(STORE_BLOCKS))
                    && (word_ext < VAL_W'(WORDS_PER_BLOCK));
  assign wr_addr  = {blk_ext[BLK_W-1:0], word_ext[WORD_SHIFT-1:0]};

  // range decode
  logic [VAL_W-1:0]   rel_full;
  logic [DEPTH_W-1:0] dec_level;
  logic [REL_W-1:0]   dec_rel;
  logic [SLOT_W-1:0]  dec_slot;
  logic [VAL_W-1:0]   dec_root;
  logic               dec_walk;

  always_comb begin
    rel_full  = logical_r - VAL_W'(DIRECT_COUNT);
    dec_rel   = '0;
    if (logical_r < VAL_W'(DIRECT_COUNT)) begin
      dec_level = DEPTH_DIRECT;
    end else if (rel_full < LIM1) begin
      dec_level = 3'd1;
      dec_rel   = REL_W'(rel_full);
    end else if (rel_full < LIM2) begin
      dec_level = 3'd2;
      dec_rel   = REL_W'(rel_full - LIM1);
    end else if (rel_full < LIM3) begin
      dec_level = 3'd3;
      dec_rel   = REL_W'(rel_full - LIM2);
    end else begin
      dec_level = DEPTH_BEYOND;
    end
    if (dec_level == DEPTH_DIRECT) begin
      dec_slot = logical_r[SLOT_W-1:0];
    end else begin
      dec_slot = SLOT_W'(DIRECT_COUNT - 1) + dec_level;
    end
    dec_root = (dec_level == DEPTH_BEYOND) ? '0 : table_r[dec_slot];
    dec_walk = (dec_level != DEPTH_DIRECT) && (dec_level != DEPTH_BEYOND)
               && (dec_root != '0);
  end

  // word index within the current tree block, most significant level first
  logic [WORD_SHIFT-1:0] idx;
  logic [ADDR_W-1:0]     rd_addr;

  always_comb begin
    case (left_r)
      2'd3:    idx = rel_r[3*WORD_SHIFT-1:2*WORD_SHIFT];
      2'd2:    idx = rel_r[2*WORD_SHIFT-1:WORD_SHIFT];
      default: idx = rel_r[WORD_SHIFT-1:0];
    endcase
  end

  assign rd_addr = {ptr_r[BLK_W-1:0], idx};

  assign stat.in_lookup    = (mode_t'(in_mode) == MODE_LOOKUP);
  assign stat.dec_walk     = dec_walk;
  assign stat.ptr_in_store = (ptr_r < VAL_W'(STORE_BLOCKS));
  assign stat.rd_zero      = (rd_data_r == '0);
  assign stat.last_level   = (left_r == LEFT_W'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ADDR_SLOTS; i++) begin
        table_r[i] <= '0;
      end
    end else if (tbl_we) begin
      table_r[in_slot_index] <= in_write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      logical_r <= in_logical_block;
      ptr_r     <= '0;
      depth_r   <= DEPTH_DIRECT;
      left_r    <= '0;
    end else if (cmd.decode) begin
      ptr_r     <= dec_root;
      rel_r     <= dec_rel;
      depth_r   <= dec_level;
      left_r    <= (dec_level == DEPTH_BEYOND) ? '0 : LEFT_W'(dec_level);
    end else if (cmd.kill) begin
      ptr_r     <= '0;
    end else if (cmd.load) begin
      ptr_r     <= rd_data_r;
      left_r    <= left_r - LEFT_W'(1);
    end
    if (cmd.emit) begin
      out_phys_r   <= ptr_r;
      out_mapped_r <= (ptr_r != '0);
      out_depth_r  <= depth_r;
    end
  end

  assign out_physical_block = out_phys_r;
  assign out_mapped         = out_mapped_r;
  assign out_depth          = out_depth_r;

endmodule

// ----- sv/block_map_walk.sv -----
// Channel   Dir  Handshake            Word
// in_ch     in   valid/ready          mode, slot_index, store_block, store_word,
//                                     write_value, logical_block
// out_ch    out  valid/ready          physical_block, mapped, depth
//
// Per word, write and idle words pass from acceptance straight to the finish state;
// lookups direct or beyond reach go through decode first, and each tree level adds a
// walk and a load state, set by the single read port of the block store and its
// registered read data. The result loads as the block returns to idle, ready for the next word.
// One word in flight; a new word is accepted once the previous one has reached
// the output register, even while that result still waits on out_ch.ready.
// Synchronous active-low reset clears the address table and control; the block
// store holds no reset value.
// Top level of the block map walk; depends on bmw_pkg, bmw_if, bmw_ctrl, bmw_dpath.

module block_map_walk import bmw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  bmw_in_if.sink    in_ch,
  bmw_out_if.source out_ch
);

  bmw_cmd_t  cmd;
  bmw_stat_t stat;

  bmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  bmw_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_ch.mode),
    .in_slot_index      (in_ch.slot_index),
    .in_store_block     (in_ch.store_block),
    .in_store_word      (in_ch.store_word),
    .in_write_value     (in_ch.write_value),
    .in_logical_block   (in_ch.logical_block),
    .out_physical_block (out_ch.physical_block),
    .out_mapped         (out_ch.mapped),
    .out_depth          (out_ch.depth)
  );

  a_mapped_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.mapped == (out_ch.physical_block != '0)))
    else $error("mapped flag disagrees with physical block");

  a_beyond_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.depth == DEPTH_BEYOND)) |-> !out_ch.mapped)
    else $error("beyond-reach lookup reported mapped");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.depth <= DEPTH_BEYOND))
    else $error("depth out of range");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("accepted a word while another was in flight");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for block_map_walk: directed table, then random words of every mode.
// Needs bmw_pkg, the bmw_in_if/bmw_out_if interfaces and the block's RTL.

module tb_top import bmw_pkg::*; ();

  localparam int RANDOM_WORDS    = 1600;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int DIR_COUNT       = 24;

  typedef struct packed {
    logic [VAL_W-1:0]   phys;
    logic               mapped;
    logic [DEPTH_W-1:0] depth;
  } map_result_t;

  typedef struct packed {
    mode_t              mode;
    logic [SLOT_W-1:0]  slot;
    logic [SBLK_W-1:0]  sblk;
    logic [SWORD_W-1:0] sword;
    logic [VAL_W-1:0]   wval;
    logic [VAL_W-1:0]   lblk;
  } map_req_t;

  typedef struct packed {
    mode_t              mode;
    logic [SLOT_W-1:0]  slot;
    logic [SBLK_W-1:0]  sblk;
    logic [SWORD_W-1:0] sword;
    logic [VAL_W-1:0]   wval;
    logic [VAL_W-1:0]   lblk;
    logic               has_want;
    map_result_t        want;
  } dir_row_t;

  localparam map_result_t NO_MAP = '0;

  // Writes always come ahead of the lookups that walk through them.
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, 32'd0, 1'b1, NO_MAP},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, 32'd4, 1'b1, '{32'h0, 1'b0, 3'd1}},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, DEPTH_BEYOND}},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, DIRECT_COUNT + LIM3, 1'b1,
      '{32'h0, 1'b0, DEPTH_BEYOND}},
    '{MODE_NONE, 3'd7, 6'h3F, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_MAP},
    '{MODE_SLOT, 3'd7, 6'd0, 7'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, NO_MAP},
    '{MODE_SLOT, 3'd0, 6'd0, 7'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, NO_MAP},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, 32'd0, 1'b1, '{32'hFFFF_FFFF, 1'b1, DEPTH_DIRECT}},
    '{MODE_SLOT, 3'd4, 6'd0, 7'd0, STORE_BLOCKS - 1, 32'd0, 1'b1, NO_MAP},
    '{MODE_STORE, 3'd0, 6'd63, 7'd0, 32'hA5A5_5A5A, 32'd0, 1'b1, NO_MAP},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, 32'd4, 1'b0, NO_MAP},
    '{MODE_STORE, 3'd0, 6'd63, 7'd127, 32'h0, 32'd0, 1'b1, NO_MAP},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, DIRECT_COUNT + LIM1 - 1, 1'b1,
      '{32'h0, 1'b0, 3'd1}},
    '{MODE_SLOT, 3'd5, 6'd0, 7'd0, STORE_BLOCKS, 32'd0, 1'b1, NO_MAP},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, DIRECT_COUNT + LIM1, 1'b1, '{32'h0, 1'b0, 3'd2}},
    '{MODE_SLOT, 3'd5, 6'd0, 7'd0, 32'd1, 32'd0, 1'b1, NO_MAP},
    '{MODE_STORE, 3'd0, 6'd1, 7'd0, 32'd2, 32'd0, 1'b1, NO_MAP},
    '{MODE_STORE, 3'd0, 6'd2, 7'd0, 32'd77, 32'd0, 1'b1, NO_MAP},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, DIRECT_COUNT + LIM1, 1'b0, NO_MAP},
    '{MODE_SLOT, 3'd6, 6'd0, 7'd0, 32'd5, 32'd0, 1'b1, NO_MAP},
    '{MODE_STORE, 3'd0, 6'd5, 7'd127, 32'd6, 32'd0, 1'b1, NO_MAP},
    '{MODE_STORE, 3'd0, 6'd6, 7'd127, 32'd7, 32'd0, 1'b1, NO_MAP},
    '{MODE_STORE, 3'd0, 6'd7, 7'd127, 32'hFFFF_FFFF, 32'd0, 1'b1, NO_MAP},
    '{MODE_LOOKUP, 3'd0, 6'd0, 7'd0, 32'h0, DIRECT_COUNT + LIM3 - 1, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, 3'd3}}
  };

  logic clk = 1'b0;
  logic rst_n;

  bmw_in_if  in_ch ();
  bmw_out_if out_ch ();

  block_map_walk u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the inode address slots and the block store
  logic [VAL_W-1:0] inode_addr   [ADDR_SLOTS];
  logic [VAL_W-1:0] disk_words   [STORE_WORDS];
  bit               disk_written [STORE_WORDS];

  map_result_t pending_maps [$];
  map_result_t head_map;
  int          fail_count = 0;
  int          random_sent = 0;
  int          idle_pct = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  // Walks the tree like the block does. miss returns the first store word on the path
  // that was never written, or -1.
  function automatic void resolve_block(input logic [VAL_W-1:0] lblk,
                                        output logic [VAL_W-1:0] phys,
                                        output logic [DEPTH_W-1:0] lvl,
                                        output int miss);
    logic [63:0]      rel;
    logic [VAL_W-1:0] ptr;
    int               levels;
    int               sh;
    int               addr;
    phys = '0;
    lvl  = DEPTH_DIRECT;
    miss = -1;
    if (lblk < DIRECT_COUNT) begin
      phys = inode_addr[lblk];
      return;
    end
    rel = 64'(lblk) - 64'(DIRECT_COUNT);
    sh  = 0;
    for (levels = 1; levels <= LEVELS; levels++) begin
      sh += WORD_SHIFT;
      if (rel < (64'd1 << sh)) break;
      rel -= 64'd1 << sh;
    end
    if (levels > LEVELS) begin
      lvl = DEPTH_BEYOND;
      return;
    end
    lvl = DEPTH_W'(levels);
    ptr = inode_addr[DIRECT_COUNT - 1 + levels];
    for (int k = 0; k < levels; k++) begin
      // zero pointer or pointer past the store ends the walk unmapped
      if (ptr == '0 || ptr >= STORE_BLOCKS) return;
      sh -= WORD_SHIFT;
      addr = int'(ptr) * WORDS_PER_BLOCK + int'((rel >> sh) & (WORDS_PER_BLOCK - 1));
      if (!disk_written[addr]) begin
        miss = addr;
        return;
      end
      ptr = disk_words[addr];
    end
    phys = ptr;
  endfunction

  function automatic map_result_t apply_word(map_req_t q);
    map_result_t r;
    int          miss;
    int          addr;
    r = '0;
    case (q.mode)
      MODE_SLOT: begin
        if (q.slot < ADDR_SLOTS) inode_addr[q.slot] = q.wval;
      end
      MODE_STORE: begin
        if (q.sblk < STORE_BLOCKS && q.sword < WORDS_PER_BLOCK) begin
          addr = int'(q.sblk) * WORDS_PER_BLOCK + int'(q.sword);
          disk_words[addr]   = q.wval;
          disk_written[addr] = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        resolve_block(q.lblk, r.phys, r.depth, miss);
        r.mapped = (r.phys != '0);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic map_req_t noise_word();
    map_req_t q;
    q.mode  = MODE_NONE;
    q.slot  = SLOT_W'($urandom());
    q.sblk  = SBLK_W'($urandom());
    q.sword = SWORD_W'($urandom());
    q.wval  = $urandom();
    q.lblk  = $urandom();
    return q;
  endfunction

  // Mostly blocks inside the store so walks go deep; some zero and wild values.
  function automatic logic [VAL_W-1:0] pick_pointer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return $urandom();
    if (r < 17) return STORE_BLOCKS;
    if (r < 18) return '1;
    return $urandom_range(1, STORE_BLOCKS - 1);
  endfunction

  function automatic logic [VAL_W-1:0] pick_logical();
    int               r;
    logic [VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, DIRECT_COUNT - 1);
    if (r < 30) return DIRECT_COUNT + $urandom_range(0, SPAN1 - 1);
    if (r < 55) return DIRECT_COUNT + LIM1 + $urandom_range(0, SPAN2 - 1);
    if (r < 82) return DIRECT_COUNT + LIM2 + $urandom_range(0, SPAN3 - 1);
    if (r < 92) begin
      v = $urandom();
      return (v < DIRECT_COUNT + LIM3) ? (v | 32'h8000_0000) : v;
    end
    case ($urandom_range(0, 6))
      0: v = DIRECT_COUNT - 1;
      1: v = DIRECT_COUNT + LIM1 - 1;
      2: v = DIRECT_COUNT + LIM1;
      3: v = DIRECT_COUNT + LIM2 - 1;
      4: v = DIRECT_COUNT + LIM2;
      5: v = DIRECT_COUNT + LIM3 - 1;
      default: v = DIRECT_COUNT + LIM3;
    endcase
    return v;
  endfunction

  task automatic send_word(map_req_t q, bit has_want, map_result_t want);
    map_result_t expect_map;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= q.mode;
    in_ch.slot_index    <= q.slot;
    in_ch.store_block   <= q.sblk;
    in_ch.store_word    <= q.sword;
    in_ch.write_value   <= q.wval;
    in_ch.logical_block <= q.lblk;
    do @(posedge clk); while (!in_ch.ready);
    expect_map = apply_word(q);
    pending_maps.push_back(has_want ? want : expect_map);
  endtask

  task automatic run_random();
    map_req_t    q;
    map_req_t    fill;
    map_result_t probe;
    int          miss;
    int          r;
    while (random_sent < RANDOM_WORDS) begin
      if (random_sent >= RANDOM_WORDS - 200 || (random_sent / 150) % 4 == 3) idle_pct = 0;
      else if ((random_sent / 150) % 4 == 1) idle_pct = 60;
      else idle_pct = 25;
      q = noise_word();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        q.mode = MODE_NONE;
      end else if (r < 12) begin
        q.mode = MODE_SLOT;
        q.wval = pick_pointer();
      end else if (r < 20) begin
        q.mode = MODE_STORE;
        q.wval = pick_pointer();
      end else begin
        q.mode = MODE_LOOKUP;
        q.lblk = pick_logical();
        // fill in every unwritten word on the path before the lookup goes out
        resolve_block(q.lblk, probe.phys, probe.depth, miss);
        while (miss >= 0) begin
          fill       = noise_word();
          fill.mode  = MODE_STORE;
          fill.sblk  = SBLK_W'(miss / WORDS_PER_BLOCK);
          fill.sword = SWORD_W'(miss % WORDS_PER_BLOCK);
          fill.wval  = pick_pointer();
          send_word(fill, 1'b0, NO_MAP);
          random_sent++;
          resolve_block(q.lblk, probe.phys, probe.depth, miss);
        end
      end
      send_word(q, 1'b0, NO_MAP);
      random_sent++;
    end
  endtask

  // Result side stalls in bursts, more often as idle_pct rises
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 3) begin
      stall_left = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result word physical_block %h mapped %b depth %0d",
                 $time, out_ch.physical_block, out_ch.mapped, out_ch.depth);
        fail_count++;
      end else begin
        head_map = pending_maps.pop_front();
        if (out_ch.physical_block !== head_map.phys) begin
          $display("%0t: physical_block expected %h got %h",
                   $time, head_map.phys, out_ch.physical_block);
          fail_count++;
        end
        if (out_ch.mapped !== head_map.mapped) begin
          $display("%0t: mapped expected %b got %b", $time, head_map.mapped, out_ch.mapped);
          fail_count++;
        end
        if (out_ch.depth !== head_map.depth) begin
          $display("%0t: depth expected %0d got %0d", $time, head_map.depth, out_ch.depth);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    map_req_t q;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_SLOT;
    in_ch.slot_index    = '0;
    in_ch.store_block   = '0;
    in_ch.store_word    = '0;
    in_ch.write_value   = '0;
    in_ch.logical_block = '0;
    out_ch.ready        = 1'b0;
    for (int i = 0; i < ADDR_SLOTS; i++) inode_addr[i] = '0;
    for (int i = 0; i < STORE_WORDS; i++) disk_written[i] = 1'b0;
    idle_pct = 20;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int i = 0; i < DIR_COUNT; i++) begin
      q.mode  = DIR_ROWS[i].mode;
      q.slot  = DIR_ROWS[i].slot;
      q.sblk  = DIR_ROWS[i].sblk;
      q.sword = DIR_ROWS[i].sword;
      q.wval  = DIR_ROWS[i].wval;
      q.lblk  = DIR_ROWS[i].lblk;
      send_word(q, DIR_ROWS[i].has_want, DIR_ROWS[i].want);
    end

    run_random();

    idle_pct = 0;
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- block_map_walk.f -----
sv/bmw_pkg.sv
sv/bmw_if.sv
sv/bmw_ctrl.sv
sv/bmw_dpath.sv
sv/block_map_walk.sv
tb/sv/tb_top.sv
